// ===== rtl/order_preserving_key_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// order_preserving_key_encoder_defines
// Assertion macros used by the key encoder checker.
// ----------------------------------------------------------------------------
`ifndef ORDER_PRESERVING_KEY_ENCODER_DEFINES_SVH
`define ORDER_PRESERVING_KEY_ENCODER_DEFINES_SVH

// same-cycle implication
`define OPKE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OPKE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/opke_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// opke_pkg
// Types and constants of the order-preserving key encoder.
// ----------------------------------------------------------------------------
package opke_pkg;

	typedef enum logic [1:0] {
		CMD_INT32    = 2'd0,
		CMD_INT64    = 2'd1,
		CMD_STR_BYTE = 2'd2,
		CMD_STR_END  = 2'd3
	} cmd_t;

	localparam logic [15:0] MAX_STRING_LEN = 16'd65535;
	localparam logic [7:0]  BYTE_MARKER    = 8'h00;
	localparam logic [7:0]  TYPE_INT       = 8'h10;
	localparam logic [7:0]  TYPE_STR       = 8'h20;
	localparam logic [7:0]  STR_NUL        = 8'h00;

	localparam int JOB_BYTES   = 15;
	localparam int JOB_W       = JOB_BYTES * 8;
	localparam int LEN_W       = $clog2(JOB_BYTES + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] value;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_item;
	} result_t;

	// bytes left aligned, first byte in the top bits
	typedef struct packed {
		logic [JOB_W-1:0] bytes;
		logic [LEN_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/order_preserving_key_encoder.sv =====
// An item is written into the job queue, then loaded into the back shifter.
// Output: one byte per cycle from the back shifter while result_ready is high; a
// string byte item gives 1 byte (3 if it opens the string), a string end 3 or 5
// bytes, an integer part 8 or 12 bytes (11 or 15 if it closes a string). New
// items are taken while earlier jobs drain, as long as the job queue is not full.
// Reset: arst_n clears the string state, the job queue and the shifter.
`default_nettype none
// ----------------------------------------------------------------------------
// order_preserving_key_encoder
// Encodes integer and string key parts into an order-preserving byte stream.
// ----------------------------------------------------------------------------
module order_preserving_key_encoder import opke_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	job_t    wr_job;
	job_t    rd_job;

	opke_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_stat     (q_stat),
		.push       (push),
		.job        (wr_job)
	);

	opke_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr     (wr_job),
		.pop    (pop),
		.rd     (rd_job),
		.stat   (q_stat)
	);

	opke_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.job          (rd_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== rtl/opke_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// opke_front
// Accepts key items, tracks the open string and builds byte jobs.
// ----------------------------------------------------------------------------
module opke_front import opke_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	input  wire q_stat_t q_stat,
	output logic         push,
	output job_t         job
);

	logic        open_q;
	logic [15:0] cnt_q;
	logic        open_d;
	logic [15:0] cnt_d;
	logic        emit;
	logic        accept;
	logic [95:0] int_seg;
	logic [LEN_W-1:0] int_len;
	logic [63:0] v64;
	logic [31:0] v32;

	assign item_ready = !q_stat.full;
	assign accept     = item_valid && item_ready;
	assign push       = accept && emit;

	assign v32 = item.value[31:0] ^ 32'h8000_0000;
	assign v64 = item.value ^ 64'h8000_0000_0000_0000;

	always_comb begin
		if (item.cmd == CMD_INT32) begin
			int_seg = {BYTE_MARKER, TYPE_INT, 8'h00, 8'h04, v32, 32'h0};
			int_len = LEN_W'(8);
		end else begin
			int_seg = {BYTE_MARKER, TYPE_INT, 8'h00, 8'h08, v64};
			int_len = LEN_W'(12);
		end
	end

	always_comb begin
		open_d    = open_q;
		cnt_d     = cnt_q;
		emit      = 1'b1;
		job.bytes = '0;
		job.len   = '0;
		unique case (cmd_t'(item.cmd))
			CMD_INT32, CMD_INT64: begin
				open_d = 1'b0;
				cnt_d  = '0;
				if (open_q) begin
					job.bytes = {STR_NUL, cnt_q, int_seg};
					job.len   = int_len + LEN_W'(3);
				end else begin
					job.bytes = {int_seg, 24'h0};
					job.len   = int_len;
				end
			end
			CMD_STR_BYTE: begin
				if (!open_q) begin
					open_d    = 1'b1;
					cnt_d     = 16'd1;
					job.bytes = {BYTE_MARKER, TYPE_STR, item.value[7:0], 96'h0};
					job.len   = LEN_W'(3);
				end else if (cnt_q < MAX_STRING_LEN) begin
					cnt_d     = cnt_q + 16'd1;
					job.bytes = {item.value[7:0], 112'h0};
					job.len   = LEN_W'(1);
				end else begin
					emit = 1'b0;
				end
			end
			CMD_STR_END: begin
				open_d = 1'b0;
				cnt_d  = '0;
				if (open_q) begin
					job.bytes = {STR_NUL, cnt_q, 96'h0};
					job.len   = LEN_W'(3);
				end else begin
					job.bytes = {BYTE_MARKER, TYPE_STR, STR_NUL, 16'h0, 80'h0};
					job.len   = LEN_W'(5);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			open_q <= open_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/opke_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// opke_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module opke_fifo import opke_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr,
	input  wire logic pop,
	output job_t      rd,
	output q_stat_t   stat
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/opke_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// opke_back
// Shifts queued jobs out one byte per beat.
// ----------------------------------------------------------------------------
module opke_back import opke_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_stat_t q_stat,
	input  wire job_t    job,
	output logic         pop,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	logic [JOB_W-1:0] sh_q;
	logic [LEN_W-1:0] rem_q;
	logic             beat;

	assign result_valid        = (rem_q != '0);
	assign result.out_byte     = sh_q[JOB_W-1 -: 8];
	assign result.last_of_item = (rem_q == LEN_W'(1));
	assign beat                = result_valid && result_ready;
	assign pop = !q_stat.empty && (!result_valid || (beat && result.last_of_item));

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= job.bytes;
		end else if (beat) begin
			sh_q <= {sh_q[JOB_W-9:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (pop) begin
			rem_q <= job.len;
		end else if (beat) begin
			rem_q <= rem_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/opke_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// opke_checker
// Port-level checks of the key encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "order_preserving_key_encoder_defines.svh"

module opke_checker import opke_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_ready,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	logic item_beat;
	logic always_emits;

	assign item_beat    = item_valid && item_ready;
	assign always_emits = (item.cmd != CMD_STR_BYTE);

	`OPKE_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")
	`OPKE_ASSERT_NEXT(a_emit_follows, clk, arst_n, item_beat && always_emits, ##1 result_valid, "no output after integer or string end item")
	`OPKE_ASSERT_NOW(a_quiet_after_reset, clk, arst_n, $rose(arst_n), !result_valid, "result valid straight out of reset")

endmodule

bind order_preserving_key_encoder opke_checker u_opke_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire
